FILE: hdl/imgrs_pkg.sv
// ----------------------------------------------------------------------------
// imgrs_pkg
// Shared types and constants of the nearest / bilinear image resampler.
// ----------------------------------------------------------------------------
package imgrs_pkg;

  localparam int SAMPLE_W = 16;
  localparam int FRAC_W   = 16;
  localparam int POS_W    = 10;
  localparam int CHAN_W   = 2;
  localparam int STEP_W   = 24;
  localparam int SIZE_W   = 9;
  localparam int NCH_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int IN_DATA_W  = 40;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_WIDTH  = 3'd0,
    REG_SOURCE_HEIGHT = 3'd1,
    REG_CHANNEL_COUNT = 3'd2,
    REG_INTERP_MODE   = 3'd3,
    REG_STEP_X        = 3'd4,
    REG_STEP_Y        = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP,
    ST_CLAMP,
    ST_PICK,
    ST_FETCH,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic       vld;
    logic [1:0] idx;
    logic       bilinear;
  } blend_ctl_t;

endpackage

FILE: hdl/imgrs_blend.sv
// ----------------------------------------------------------------------------
// imgrs_blend
// Weights the samples read from the store and sums them into one result:
// pass-through in nearest mode, four-tap bilinear blend with rounding.
// ----------------------------------------------------------------------------
module imgrs_blend
  import imgrs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  blend_ctl_t          ctl,
  input  logic [SAMPLE_W-1:0] rdata,
  input  logic [FRAC_W-1:0]   frac_x,
  input  logic [FRAC_W-1:0]   frac_y,
  output logic                done,
  output logic [SAMPLE_W-1:0] value
);

  localparam int WT_W  = FRAC_W + 1;
  localparam int MP_W  = SAMPLE_W + WT_W;
  localparam int ROW_W = SAMPLE_W + FRAC_W;
  localparam int ACC_W = ROW_W + WT_W;

  logic [WT_W-1:0]  wx;
  logic [WT_W-1:0]  wy;
  logic [MP_W-1:0]  mul_p;
  logic             mul_vld;
  logic [1:0]       mul_idx;
  logic [MP_W-1:0]  row_part;
  logic [MP_W-1:0]  row_sum;
  logic [ROW_W-1:0] row_tot;
  logic             row_vld;
  logic             row_last;
  logic [ACC_W-1:0] acc_p;
  logic             accp_vld;
  logic             accp_last;
  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] total;

  always_comb begin
    wx = ctl.idx[0] ? {1'b0, frac_x} : WT_W'(17'h10000 - {1'b0, frac_x});
    wy = row_last ? {1'b0, frac_y} : WT_W'(17'h10000 - {1'b0, frac_y});
    row_sum = row_part + mul_p;
    total = acc + acc_p + ACC_W'(33'h080000000);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_vld  <= 1'b0;
      row_vld  <= 1'b0;
      accp_vld <= 1'b0;
    end else begin
      mul_vld  <= ctl.vld && ctl.bilinear;
      row_vld  <= mul_vld && mul_idx[0];
      accp_vld <= row_vld;
    end
  end

  always_ff @(posedge clk) begin
    mul_p   <= MP_W'(rdata) * MP_W'(wx);
    mul_idx <= ctl.idx;
    if (mul_vld && !mul_idx[0]) begin
      row_part <= mul_p;
    end
    if (mul_vld && mul_idx[0]) begin
      row_tot  <= row_sum[ROW_W-1:0];
      row_last <= mul_idx[1];
    end
    acc_p     <= ACC_W'(row_tot) * ACC_W'(wy);
    accp_last <= row_last;
    if (accp_vld && !accp_last) begin
      acc <= acc_p;
    end
  end

  always_comb begin
    done  = (ctl.vld && !ctl.bilinear) || (accp_vld && accp_last);
    value = rdata;
    if (accp_vld && accp_last) begin
      value = total[ACC_W-1] ? '1 : total[ACC_W-2 -: SAMPLE_W];
    end
  end

endmodule

FILE: hdl/image_resample_nearest_bilinear.sv
// ----------------------------------------------------------------------------
// image_resample_nearest_bilinear
// Source image store with nearest or bilinear resampled reads.
//
//   channel  direction  handshake         payload
//   s_*      in         tvalid / tready   tdata: pos_x, pos_y, chan, sample_in
//                                         tuser: func
//   m_*      out        tvalid / tready   tdata: sample_out
//   cfg_*    in         valid / ready     index, data
//
// A write item is stored as it is accepted, and the block stays idle. A read
// passes MAP, CLAMP, PICK and FETCH, then the store read; a bilinear read
// fetches four samples over the single store port (one sample a cycle), then
// the blend pipeline. A new item is taken once the previous read has its
// result registered. The store is not cleared on reset; rst clears control
// and restores the register defaults. The result register holds while m_tready is low.
// ----------------------------------------------------------------------------
module image_resample_nearest_bilinear
  import imgrs_pkg::*;
#(
  parameter int MAX_WIDTH    = 256,
  parameter int MAX_HEIGHT   = 256,
  parameter int MAX_CHANNELS = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // pos_x, pos_y, chan, sample_in, zero pad
  input  logic                  s_tuser,   // func
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [SAMPLE_W-1:0]   m_tdata,   // sample_out
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int CHW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int UW     = CW + FRAC_W;
  localparam int VW     = RW + FRAC_W;
  localparam int RAW_W  = POS_W + STEP_W + 2;
  localparam int PROD_W = POS_W + STEP_W;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [CW-1:0] col,
                                                input logic [RW-1:0] row,
                                                input logic [CHW-1:0] ch);
    logic [ADDR_W-1:0] pix;
    pix = ADDR_W'(row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col);
    return ADDR_W'(pix * ADDR_W'(MAX_CHANNELS) + ADDR_W'(ch));
  endfunction

  logic [SIZE_W-1:0] source_width;
  logic [SIZE_W-1:0] source_height;
  logic [NCH_W-1:0]  channel_count;
  logic              interp_mode;
  logic [STEP_W-1:0] step_x;
  logic [STEP_W-1:0] step_y;

  state_t state;
  state_t state_next;

  logic [POS_W-1:0]    in_x;
  logic [POS_W-1:0]    in_y;
  logic [CHAN_W-1:0]   in_chan;
  logic [SAMPLE_W-1:0] in_sample;
  logic                s_accept;
  logic                in_range;

  logic [CW-1:0]  wm1;
  logic [RW-1:0]  hm1;
  logic [CHW-1:0] ncm1;

  logic [POS_W-1:0]  px;
  logic [POS_W-1:0]  py;
  logic [CHW-1:0]    ch;
  logic signed [RAW_W-1:0] u_raw;
  logic signed [RAW_W-1:0] v_raw;
  logic [UW-1:0]     u_sat;
  logic [VW-1:0]     v_sat;
  logic [UW-1:0]     u_top;
  logic [VW-1:0]     v_top;
  logic [PROD_W-1:0] prod_x;
  logic [PROD_W-1:0] prod_y;

  logic [CW-1:0]     x0;
  logic [RW-1:0]     y0;
  logic [FRAC_W-1:0] fx;
  logic [FRAC_W-1:0] fy;
  logic [CW:0]       x_inc;
  logic [RW:0]       y_inc;
  logic [CW:0]       x_rnd;
  logic [RW:0]       y_rnd;
  logic [CW-1:0]     x_near;
  logic [RW-1:0]     y_near;
  logic [CW-1:0]     x_next;
  logic [RW-1:0]     y_next;

  logic [CW-1:0]     col_a;
  logic [CW-1:0]     col_b;
  logic [RW-1:0]     row_a;
  logic [RW-1:0]     row_b;
  logic [FRAC_W-1:0] frac_x;
  logic [FRAC_W-1:0] frac_y;
  logic [1:0]        k;
  logic              k_last;
  logic              out_free;

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [ADDR_W-1:0]   mem_addr;
  logic                mem_we;
  logic [SAMPLE_W-1:0] rdata;
  logic                rd_vld;
  logic [1:0]          rd_k;

  blend_ctl_t          blend_ctl;
  logic                done;
  logic [SAMPLE_W-1:0] value;
  logic [SAMPLE_W-1:0] out_data;
  logic                out_valid;

  assign in_x      = s_tdata[POS_W-1:0];
  assign in_y      = s_tdata[2*POS_W-1:POS_W];
  assign in_chan   = s_tdata[2*POS_W+CHAN_W-1:2*POS_W];
  assign in_sample = s_tdata[2*POS_W+CHAN_W+SAMPLE_W-1:2*POS_W+CHAN_W];

  assign s_tready  = (state == ST_IDLE);
  assign s_accept  = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;
  assign out_free  = !out_valid || m_tready;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= SIZE_W'(256);
      source_height <= SIZE_W'(256);
      channel_count <= NCH_W'(1);
      interp_mode   <= 1'b0;
      step_x        <= STEP_W'(65536);
      step_y        <= STEP_W'(65536);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SOURCE_WIDTH:  source_width  <= cfg_data[SIZE_W-1:0];
        REG_SOURCE_HEIGHT: source_height <= cfg_data[SIZE_W-1:0];
        REG_CHANNEL_COUNT: channel_count <= cfg_data[NCH_W-1:0];
        REG_INTERP_MODE:   interp_mode   <= cfg_data[0];
        REG_STEP_X:        step_x        <= cfg_data[STEP_W-1:0];
        REG_STEP_Y:        step_y        <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (source_width == '0) begin
      wm1 = '0;
    end else if (32'(source_width) > 32'(MAX_WIDTH)) begin
      wm1 = CW'(MAX_WIDTH - 1);
    end else begin
      wm1 = CW'(source_width - SIZE_W'(1));
    end
    if (source_height == '0) begin
      hm1 = '0;
    end else if (32'(source_height) > 32'(MAX_HEIGHT)) begin
      hm1 = RW'(MAX_HEIGHT - 1);
    end else begin
      hm1 = RW'(source_height - SIZE_W'(1));
    end
    if (channel_count == '0) begin
      ncm1 = '0;
    end else if (32'(channel_count) > 32'(MAX_CHANNELS)) begin
      ncm1 = CHW'(MAX_CHANNELS - 1);
    end else begin
      ncm1 = CHW'(channel_count - NCH_W'(1));
    end
    in_range = (32'(in_x) < 32'(MAX_WIDTH)) && (32'(in_y) < 32'(MAX_HEIGHT)) &&
               (32'(in_chan) < 32'(MAX_CHANNELS));
  end

  // state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    k_last     = interp_mode ? (k == 2'd3) : (k == 2'd0);
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_accept && s_tuser == FUNC_READ) state_next = ST_MAP;
      ST_MAP:   state_next = ST_CLAMP;
      ST_CLAMP: state_next = ST_PICK;
      ST_PICK:  if (out_free) state_next = ST_FETCH;
      ST_FETCH: if (k_last) state_next = ST_DRAIN;
      ST_DRAIN: if (done) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // map back, saturate, pick neighbors
  always_comb begin
    prod_x = PROD_W'(px) * PROD_W'(step_x);
    prod_y = PROD_W'(py) * PROD_W'(step_y);
    u_top  = {wm1, FRAC_W'(0)};
    v_top  = {hm1, FRAC_W'(0)};
    x0     = u_sat[UW-1:FRAC_W];
    fx     = u_sat[FRAC_W-1:0];
    y0     = v_sat[VW-1:FRAC_W];
    fy     = v_sat[FRAC_W-1:0];
    x_inc  = {1'b0, x0} + (CW+1)'(1);
    y_inc  = {1'b0, y0} + (RW+1)'(1);
    x_rnd  = ((fx > 16'h8000) || (fx == 16'h8000 && x0[0])) ? x_inc : {1'b0, x0};
    y_rnd  = ((fy > 16'h8000) || (fy == 16'h8000 && y0[0])) ? y_inc : {1'b0, y0};
    x_near = (x_rnd > {1'b0, wm1}) ? wm1 : x_rnd[CW-1:0];
    y_near = (y_rnd > {1'b0, hm1}) ? hm1 : y_rnd[RW-1:0];
    x_next = (x_inc > {1'b0, wm1}) ? wm1 : x_inc[CW-1:0];
    y_next = (y_inc > {1'b0, hm1}) ? hm1 : y_inc[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      px <= in_x;
      py <= in_y;
      ch <= (32'(in_chan) > 32'(ncm1)) ? ncm1 : CHW'(in_chan);
    end
    if (state == ST_MAP) begin
      u_raw <= $signed(RAW_W'(prod_x) + RAW_W'(step_x >> 1)) - RAW_W'(32768);
      v_raw <= $signed(RAW_W'(prod_y) + RAW_W'(step_y >> 1)) - RAW_W'(32768);
    end
    if (state == ST_CLAMP) begin
      if (u_raw < 0) begin
        u_sat <= '0;
      end else if (u_raw > $signed(RAW_W'(u_top))) begin
        u_sat <= u_top;
      end else begin
        u_sat <= u_raw[UW-1:0];
      end
      if (v_raw < 0) begin
        v_sat <= '0;
      end else if (v_raw > $signed(RAW_W'(v_top))) begin
        v_sat <= v_top;
      end else begin
        v_sat <= v_raw[VW-1:0];
      end
    end
    if (state == ST_PICK) begin
      col_a  <= interp_mode ? x0 : x_near;
      row_a  <= interp_mode ? y0 : y_near;
      col_b  <= x_next;
      row_b  <= y_next;
      frac_x <= fx;
      frac_y <= fy;
      k      <= 2'd0;
    end else if (state == ST_FETCH) begin
      k <= k + 2'd1;
    end
  end

  // source store, one port
  always_comb begin
    mem_we = s_accept && (s_tuser == FUNC_WRITE) && in_range;
    if (state == ST_FETCH) begin
      mem_addr = addr_of(k[0] ? col_b : col_a, k[1] ? row_b : row_a, ch);
    end else begin
      mem_addr = addr_of(CW'(in_x), RW'(in_y), CHW'(in_chan));
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= in_sample;
    end
    rdata <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= (state == ST_FETCH);
    end
    rd_k <= k;
  end

  assign blend_ctl = '{vld: rd_vld, idx: rd_k, bilinear: interp_mode};

  imgrs_blend u_blend (
    .clk    (clk),
    .rst    (rst),
    .ctl    (blend_ctl),
    .rdata  (rdata),
    .frac_x (frac_x),
    .frac_y (frac_y),
    .done   (done),
    .value  (value)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_data <= value;
    end
  end

endmodule

FILE: hdl/imgrs_checker.sv
// ----------------------------------------------------------------------------
// imgrs_checker
// Port-level checks of the resampler: result timing and handshake.
// ----------------------------------------------------------------------------
module imgrs_checker
  import imgrs_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                s_tuser,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [SAMPLE_W-1:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped or changed while stalled");

  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == FUNC_WRITE && !m_tvalid |=> !m_tvalid)
    else $error("write item produced a result");

  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == FUNC_READ |=> !s_tready)
    else $error("input taken while a read is in progress");

  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == FUNC_READ && !m_tvalid |=> !m_tvalid)
    else $error("read result appeared too early");

endmodule

bind image_resample_nearest_bilinear imgrs_checker u_imgrs_checker (.*);
